/* src/b64s_pkg.sv */
// Shared types, constants and character mapping functions for the base64url codec.
`timescale 1ns / 1ps
`default_nettype none

package b64s_pkg;

  // Start values of the pending bit count, by direction.
  localparam logic signed [4:0] ENC_START = -5'sd6;
  localparam logic signed [4:0] DEC_START = -5'sd8;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

  localparam int unsigned ACC_W = 14;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_message;
    logic       bad_input;
  } result_t;

  // Work handed from the front to the back: one or two results.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } cmd_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // 6-bit group to base64url character.
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'(8'h41 + {2'b00, v});
    end else if (v < 6'd52) begin
      c = 8'(8'h61 + {2'b00, v} - 8'd26);
    end else if (v < 6'd62) begin
      c = 8'(8'h30 + {2'b00, v} - 8'd52);
    end else if (v == 6'd62) begin
      c = 8'h2D;
    end else begin
      c = 8'h5F;
    end
    return c;
  endfunction

  // Character to {valid, 6-bit group}; both url and standard alphabets for 62 and 63.
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2D || c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h5F || c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/base64url_stream_codec.sv */
// Top level of the streaming base64url encoder/decoder.
//
// Usage:
//   Input channel (in_valid / in_stall, data_byte, last_item): one byte per
//   item. An item is taken at a rising edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall, out_byte, byte_valid,
//   end_of_message, bad_input): zero to two result items per input item.
//   cfg_wr_en / cfg_wr_data write the direction register (0 encode, 1 decode)
//   and clear the message state; write it only while the block is idle.
//   The first result of an item is registered in the command queue, then in
//   the output register. Throughput: decoding takes one item per cycle while
//   the receiver does not stall; an encoded item with two characters uses the
//   single output register twice, as it carries one result per unstalled cycle.
//   The front end takes a new item every cycle while the 2-entry queue has room.
//   Reset (rst, synchronous): direction goes to encode, the message state and
//   the queue are cleared, out_valid drops.
//   When the receiver stalls, the output item holds, the queue fills, and
//   in_stall rises once both queue entries are taken.
`timescale 1ns / 1ps
`default_nettype none

module base64url_stream_codec (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             end_of_message,
  output logic             bad_input
);

  b64s_pkg::q_status_t q_status;
  b64s_pkg::cmd_t      push_cmd;
  b64s_pkg::cmd_t      head;
  b64s_pkg::result_t   out_res;
  logic                push;
  logic                pop;

  // Classify the item, advance the bit stream, build a command.
  b64s_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .last_item  (last_item),
    .q_status   (q_status),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // Decouple the two sides so each can stall on its own.
  b64s_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .q_status(q_status)
  );

  // Drain commands one result per cycle while the receiver does not stall.
  b64s_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  assign out_byte       = out_res.out_byte;
  assign byte_valid     = out_res.byte_valid;
  assign end_of_message = out_res.end_of_message;
  assign bad_input      = out_res.bad_input;

endmodule

`default_nettype wire

/* src/b64s_front.sv */
// Front end: accepts items, tracks the bit stream and builds result commands.
`timescale 1ns / 1ps
`default_nettype none

module b64s_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic                 cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 last_item,
  input  wire b64s_pkg::q_status_t  q_status,
  output logic                      push,
  output b64s_pkg::cmd_t            push_cmd
);

  logic                              direction;
  logic [b64s_pkg::ACC_W-1:0]        acc;
  logic signed [4:0]                 pending;
  logic                              pad_seen;
  logic                              error_seen;

  logic [b64s_pkg::ACC_W-1:0]        acc_next;
  logic signed [4:0]                 pending_next;
  logic                              pad_next;
  logic                              error_next;

  logic [b64s_pkg::ACC_W-1:0]        acc_enc;
  logic signed [4:0]                 p_enc1;
  logic signed [4:0]                 p_enc2;
  logic signed [4:0]                 p_neg;
  logic                              emit2;
  logic                              flush;
  logic [7:0]                        char0;
  logic [7:0]                        char1;
  logic [7:0]                        char_fl;

  logic [b64s_pkg::ACC_W-1:0]        acc_dec;
  logic signed [4:0]                 p_dec;
  logic [6:0]                        dec_sx;
  logic                              active;
  logic                              is_pad;
  logic                              emitd;
  logic [7:0]                        dec_byte;

  logic                              accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    // encode path
    acc_enc = {acc[5:0], data_byte};
    p_enc1  = pending + 5'sd8;
    p_enc2  = p_enc1 - 5'sd6;
    p_neg   = -p_enc2;
    emit2   = !p_enc2[4];
    flush   = last_item && !emit2 && (p_enc2 > -5'sd6);
    char0   = b64s_pkg::sextet_char(6'(acc_enc >> p_enc1[3:0]));
    char1   = b64s_pkg::sextet_char(6'(acc_enc >> p_enc2[3:0]));
    char_fl = b64s_pkg::sextet_char(6'(acc_enc << p_neg[2:0]));

    // decode path
    active   = !pad_seen && !error_seen;
    is_pad   = (data_byte == b64s_pkg::PAD_CHAR);
    dec_sx   = b64s_pkg::char_sextet(data_byte);
    acc_dec  = {acc[7:0], dec_sx[5:0]};
    p_dec    = pending + 5'sd6;
    emitd    = active && !is_pad && dec_sx[6] && !p_dec[4];
    dec_byte = 8'(acc_dec >> p_dec[3:0]);

    acc_next     = acc;
    pending_next = pending;
    pad_next     = pad_seen;
    error_next   = error_seen;
    push         = 1'b0;
    push_cmd     = '0;

    if (direction == b64s_pkg::DIR_ENCODE) begin
      acc_next          = acc_enc;
      pending_next      = emit2 ? p_enc2 - 5'sd6 : p_enc2;
      push              = 1'b1;
      push_cmd.two      = emit2 || flush;
      push_cmd.r0       = '{out_byte: char0, byte_valid: 1'b1,
                            end_of_message: last_item && !(emit2 || flush), bad_input: 1'b0};
      push_cmd.r1       = '{out_byte: emit2 ? char1 : char_fl, byte_valid: 1'b1,
                            end_of_message: last_item, bad_input: 1'b0};
    end else begin
      if (active) begin
        if (is_pad) begin
          pad_next = 1'b1;
        end else if (!dec_sx[6]) begin
          error_next = 1'b1;
        end else begin
          acc_next     = acc_dec;
          pending_next = emitd ? p_dec - 5'sd8 : p_dec;
        end
      end
      push         = emitd || last_item;
      push_cmd.two = 1'b0;
      if (emitd) begin
        push_cmd.r0 = '{out_byte: dec_byte, byte_valid: 1'b1,
                        end_of_message: last_item, bad_input: last_item && error_next};
      end else begin
        push_cmd.r0 = '{out_byte: 8'd0, byte_valid: 1'b0,
                        end_of_message: 1'b1, bad_input: error_next};
      end
    end
    push = push && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= b64s_pkg::DIR_ENCODE;
      acc        <= '0;
      pending    <= b64s_pkg::ENC_START;
      pad_seen   <= 1'b0;
      error_seen <= 1'b0;
    end else if (cfg_wr_en) begin
      direction  <= cfg_wr_data;
      acc        <= '0;
      pending    <= cfg_wr_data ? b64s_pkg::DEC_START : b64s_pkg::ENC_START;
      pad_seen   <= 1'b0;
      error_seen <= 1'b0;
    end else if (accept) begin
      if (last_item) begin
        acc        <= '0;
        pending    <= direction ? b64s_pkg::DEC_START : b64s_pkg::ENC_START;
        pad_seen   <= 1'b0;
        error_seen <= 1'b0;
      end else begin
        acc        <= acc_next;
        pending    <= pending_next;
        pad_seen   <= pad_next;
        error_seen <= error_next;
      end
    end
  end

endmodule

`default_nettype wire

/* src/b64s_queue.sv */
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module b64s_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire b64s_pkg::cmd_t       push_cmd,
  input  wire logic                 pop,
  output b64s_pkg::cmd_t            head,
  output b64s_pkg::q_status_t       q_status
);

  b64s_pkg::cmd_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign head           = slot[rd_ptr];
  assign q_status.full  = (count == 2'd2);
  assign q_status.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/b64s_back.sv */
// Back end: plays out one or two results per command through the output register.
`timescale 1ns / 1ps
`default_nettype none

module b64s_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire b64s_pkg::cmd_t       head,
  input  wire b64s_pkg::q_status_t  q_status,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output b64s_pkg::result_t         out_res
);

  logic               hold2;
  b64s_pkg::result_t  second;
  logic               load;

  assign load = !out_valid || !out_stall;
  assign pop  = load && !hold2 && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hold2     <= 1'b0;
    end else if (load) begin
      if (hold2) begin
        out_valid <= 1'b1;
        hold2     <= 1'b0;
      end else if (!q_status.empty) begin
        out_valid <= 1'b1;
        hold2     <= head.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (hold2) begin
        out_res <= second;
      end else if (!q_status.empty) begin
        out_res <= head.r0;
        second  <= head.r1;
      end
    end
  end

endmodule

`default_nettype wire

/* src/b64s_checker.sv */
// Port-level checks for the base64url codec and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module b64s_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_byte,
  input wire logic        byte_valid,
  input wire logic        end_of_message,
  input wire logic        bad_input
);

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // A bare end marker only closes a message.
  a_bare_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> end_of_message)
    else $error("bare marker without end_of_message");

  // The error flag rides on the end result only.
  a_bad_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_input |-> end_of_message)
    else $error("bad_input outside the end result");

  // A stalled output item holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(byte_valid)
      && $stable(end_of_message) && $stable(bad_input))
    else $error("stalled output item changed");

endmodule

bind base64url_stream_codec b64s_checker u_b64s_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_byte      (out_byte),
  .byte_valid    (byte_valid),
  .end_of_message(end_of_message),
  .bad_input     (bad_input)
);

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for the base64url stream codec: directed table, then random messages.
`timescale 1ns / 1ps

module testbench;

  localparam string ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
  localparam int PREDICT = -1;      // row result comes from the predictor
  localparam int SETTLE = 6;        // cycles for items that yield nothing to drain
  localparam int ITEM_GOAL = 1500;
  localparam b64s_pkg::result_t NONE = '0;
  localparam logic ENC = b64s_pkg::DIR_ENCODE;
  localparam logic DEC = b64s_pkg::DIR_DECODE;

  typedef enum logic {ROW_BYTE, ROW_DIR} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic              dir;
    logic [7:0]        b;
    logic              lst;
    int                typed;       // number of typed results, or PREDICT
    b64s_pkg::result_t r0;
    b64s_pkg::result_t r1;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       last_item = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_message;
  logic       bad_input;

  base64url_stream_codec dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .last_item(last_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .byte_valid(byte_valid),
    .end_of_message(end_of_message), .bad_input(bad_input)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: direction plus the message in progress.
  logic        cur_dir = ENC;
  logic [13:0] acc_bits = '0;
  int          avail = -6;          // bits ready beyond one output group, signed
  bit          pad_hit = 0;
  bit          bad_hit = 0;

  b64s_pkg::result_t converted_q[$];  // results still owed by the block
  bit      tx_burst = 0;            // sender may idle between items unless set
  bit      rx_burst = 0;            // receiver may stall unless set
  int      mismatches = 0;
  int      counted = 0;
  int      results_seen = 0;
  int      enc_msgs = 0;
  int      dec_msgs = 0;
  int      dir_writes = 0;
  int      stall_cnt = 0;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    return ALPHABET[v];
  endfunction

  // Map a character to its 6-bit group; return 0 when outside the alphabet.
  function automatic bit dec_group(input logic [7:0] c, output logic [5:0] g);
    g = '0;
    if (c == "+") begin
      g = 6'd62;
      return 1;
    end
    if (c == "/") begin
      g = 6'd63;
      return 1;
    end
    for (int i = 0; i < 64; i++) begin
      if (ALPHABET[i] == c) begin
        g = 6'(i);
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic b64s_pkg::result_t data_res(input logic [7:0] v, input logic ok);
    b64s_pkg::result_t r;
    r = NONE;
    r.out_byte = v;
    r.byte_valid = ok;
    return r;
  endfunction

  function automatic void clear_msg_state();
    acc_bits = '0;
    avail = (cur_dir == DEC) ? -8 : -6;
    pad_hit = 0;
    bad_hit = 0;
  endfunction

  // Advance the predictor by one accepted item; return how many results it owes.
  function automatic int convert_byte(input logic [7:0] b, input logic lst,
                                      output b64s_pkg::result_t outs[2], output bit ignored);
    int n;
    logic [5:0] g;
    logic [31:0] wide;
    n = 0;
    ignored = 0;
    outs[0] = NONE;
    outs[1] = NONE;
    if (cur_dir == ENC) begin
      acc_bits = {acc_bits[5:0], b};
      avail += 8;
      while (avail >= 0 && n < 2) begin
        outs[n] = data_res(enc_char(6'(acc_bits >> avail)), 1'b1);
        n++;
        avail -= 6;
      end
      // flush leftover bits left-aligned
      if (lst && avail > -6 && n < 2) begin
        wide = 32'(acc_bits) << (-avail);
        outs[n] = data_res(enc_char(wide[5:0]), 1'b1);
        n++;
      end
    end else begin
      if (!pad_hit && !bad_hit) begin
        if (b == b64s_pkg::PAD_CHAR) begin
          pad_hit = 1;
        end else if (!dec_group(b, g)) begin
          bad_hit = 1;
        end else begin
          acc_bits = {acc_bits[7:0], g};
          avail += 6;
          if (avail >= 0) begin
            outs[n] = data_res(8'(acc_bits >> avail), 1'b1);
            n++;
            avail -= 8;
          end
        end
      end else begin
        ignored = !lst;
      end
      if (lst && n == 0) begin
        outs[n] = data_res(8'h00, 1'b0);
        n++;
      end
    end
    if (lst) begin
      outs[n-1].end_of_message = 1'b1;
      outs[n-1].bad_input = (cur_dir == DEC) && bad_hit;
      clear_msg_state();
    end
    return n;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Offer one item, hold it until taken, then queue what it must produce.
  // Returns at the accepting edge with in_valid still high.
  task automatic push_byte(input logic [7:0] b, input logic lst, input int typed,
                           input b64s_pkg::result_t t0, input b64s_pkg::result_t t1);
    int gap;
    int n;
    bit ign;
    b64s_pkg::result_t outs[2];
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_item <= lst;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (lst) begin
      if (cur_dir == ENC) enc_msgs++;
      else dec_msgs++;
    end
    n = convert_byte(b, lst, outs, ign);
    if (!ign) counted++;
    if (typed == PREDICT) begin
      for (int i = 0; i < n; i++) converted_q = {converted_q, outs[i]};
    end else begin
      if (typed > 0) converted_q = {converted_q, t0};
      if (typed > 1) converted_q = {converted_q, t1};
    end
  endtask

  // Drop valid and hold off until every owed result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (converted_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_direction(input logic d);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_dir = d;
    clear_msg_state();
    dir_writes++;
  endtask

  task automatic encode_message();
    int len;
    logic [7:0] b;
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      push_byte(b, i == len - 1, PREDICT, NONE, NONE);
    end
  endtask

  function automatic logic [7:0] good_char();
    logic [5:0] g;
    g = 6'($urandom_range(0, 63));
    if (g == 6'd62 && $urandom_range(0, 1)) return "+";
    if (g == 6'd63 && $urandom_range(0, 1)) return "/";
    return enc_char(g);
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    logic [5:0] g;
    do c = 8'($urandom_range(0, 255));
    while (dec_group(c, g) || c == b64s_pkg::PAD_CHAR);
    return c;
  endfunction

  // Mostly well-formed character streams; some padded, broken or pure noise.
  task automatic decode_message();
    logic [7:0] msg[$];
    int shape;
    int len;
    shape = $urandom_range(0, 9);
    len = $urandom_range(1, 14);
    if (shape == 9) begin
      repeat ($urandom_range(1, 6)) msg = {msg, 8'($urandom_range(0, 255))};
    end else begin
      repeat (len) msg = {msg, good_char()};
      if (shape == 6 || shape == 7) begin
        repeat ($urandom_range(1, 2)) msg = {msg, b64s_pkg::PAD_CHAR};
        repeat ($urandom_range(0, 3)) msg = {msg, 8'($urandom_range(0, 255))};
      end else if (shape == 8) begin
        msg.insert($urandom_range(0, len), bad_char());
        repeat ($urandom_range(0, 3)) msg = {msg, 8'($urandom_range(0, 255))};
      end
    end
    foreach (msg[i]) push_byte(msg[i], i == msg.size() - 1, PREDICT, NONE, NONE);
  endtask

  // Result side: check each accepted item, then draw the next stall.
  always @(posedge clk) begin
    b64s_pkg::result_t got;
    b64s_pkg::result_t want;
    int hold;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{out_byte, byte_valid, end_of_message, bad_input};
      results_seen++;
      if (converted_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %h/%b/%b/%b", got.out_byte,
                                got.byte_valid, got.end_of_message, got.bad_input));
      end else begin
        want = converted_q.pop_front();
        if (got.out_byte !== want.out_byte)
          flag_mismatch($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
        if (got.byte_valid !== want.byte_valid)
          flag_mismatch($sformatf("byte_valid %b, expected %b", got.byte_valid,
                                  want.byte_valid));
        if (got.end_of_message !== want.end_of_message)
          flag_mismatch($sformatf("end_of_message %b, expected %b", got.end_of_message,
                                  want.end_of_message));
        if (got.bad_input !== want.bad_input)
          flag_mismatch($sformatf("bad_input %b, expected %b", got.bad_input,
                                  want.bad_input));
      end
      hold = rx_burst ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall <= 1'b1;
        stall_cnt <= hold - 1;
      end
    end else if (out_stall) begin
      if (stall_cnt == 0) out_stall <= 1'b0;
      else stall_cnt <= stall_cnt - 1;
    end
  end

  // Directed rows: reset value of the direction, byte extremes, flush paths,
  // both spellings of groups 62 and 63, padding, invalid characters, bare end
  // markers and messages abandoned by a direction write.
  stim_row_t directed[] = '{
    '{ROW_BYTE, ENC, 8'h00, 1'b1, 2, '{"A", 1'b1, 1'b0, 1'b0}, '{"A", 1'b1, 1'b1, 1'b0}},
    '{ROW_BYTE, ENC, 8'hFF, 1'b1, 2, '{"_", 1'b1, 1'b0, 1'b0}, '{"w", 1'b1, 1'b1, 1'b0}},
    '{ROW_BYTE, ENC, 8'hFB, 1'b0, PREDICT, NONE, NONE},
    '{ROW_BYTE, ENC, 8'hFF, 1'b0, PREDICT, NONE, NONE},
    '{ROW_BYTE, ENC, 8'hBF, 1'b1, PREDICT, NONE, NONE},
    '{ROW_BYTE, ENC, 8'h80, 1'b0, PREDICT, NONE, NONE},
    '{ROW_BYTE, ENC, 8'h01, 1'b1, PREDICT, NONE, NONE},
    '{ROW_BYTE, ENC, 8'h55, 1'b0, PREDICT, NONE, NONE},
    '{ROW_DIR,  DEC, 8'h00, 1'b0, PREDICT, NONE, NONE},
    '{ROW_BYTE, ENC, "Q",   1'b0, 0, NONE, NONE},
    '{ROW_BYTE, ENC, "Q",   1'b1, 1, '{8'h41, 1'b1, 1'b1, 1'b0}, NONE},
    '{ROW_BYTE, ENC, "-",   1'b0, PREDICT, NONE, NONE},
    '{ROW_BYTE, ENC, "+",   1'b0, PREDICT, NONE, NONE},
    '{ROW_BYTE, ENC, "_",   1'b0, PREDICT, NONE, NONE},
    '{ROW_BYTE, ENC, "/",   1'b1, PREDICT, NONE, NONE},
    '{ROW_BYTE, ENC, "A",   1'b0, 0, NONE, NONE},
    '{ROW_BYTE, ENC, "=",   1'b0, 0, NONE, NONE},
    '{ROW_BYTE, ENC, "B",   1'b0, 0, NONE, NONE},
    '{ROW_BYTE, ENC, "C",   1'b1, 1, '{8'h00, 1'b0, 1'b1, 1'b0}, NONE},
    '{ROW_BYTE, ENC, 8'h80, 1'b0, 0, NONE, NONE},
    '{ROW_BYTE, ENC, "A",   1'b0, 0, NONE, NONE},
    '{ROW_BYTE, ENC, "A",   1'b1, 1, '{8'h00, 1'b0, 1'b1, 1'b1}, NONE},
    '{ROW_BYTE, ENC, "=",   1'b1, 1, '{8'h00, 1'b0, 1'b1, 1'b0}, NONE},
    '{ROW_BYTE, ENC, "z",   1'b0, PREDICT, NONE, NONE},
    '{ROW_DIR,  ENC, 8'h00, 1'b0, PREDICT, NONE, NONE},
    '{ROW_BYTE, ENC, 8'h7E, 1'b1, PREDICT, NONE, NONE}
  };

  initial begin
    clear_msg_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_DIR) set_direction(directed[i].dir);
      else push_byte(directed[i].b, directed[i].lst, directed[i].typed,
                     directed[i].r0, directed[i].r1);
    end

    // Random phases: each sets the direction on an idle block, then sends messages.
    while (counted < ITEM_GOAL) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      set_direction(1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 6)) begin
        if (cur_dir == ENC) encode_message();
        else decode_message();
      end
      // leave a message open so the next direction write abandons it
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          if (cur_dir == ENC) push_byte(8'($urandom_range(0, 255)), 1'b0,
                                        PREDICT, NONE, NONE);
          else push_byte(good_char(), 1'b0, PREDICT, NONE, NONE);
        end
      end
    end

    drain_results();
    $display("Run covered %0d counted items, %0d encode and %0d decode messages,",
             counted, enc_msgs, dec_msgs);
    $display("%0d direction writes and %0d results compared.", dir_writes, results_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(10_000_000);
    $display("watchdog expired with %0d results outstanding", converted_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
